@@ rtl/core/mbv_pkg.sv @@
// Package for the median battery voltage block: field widths, constants,
// register indexes, beat and link types and the arithmetic state encoding.
// No dependencies.
package mbv_pkg;

  // Field widths
  localparam int unsigned CODE_W = 12;
  localparam int unsigned MV_W   = 16;
  localparam int unsigned RES_W  = 20;
  localparam int unsigned OFF_W  = 12;

  // Register file: index decoded from paddr[3:2]
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned IDX_W  = 2;
  localparam logic [IDX_W-1:0] REG_DIV_TOP = 2'd0;
  localparam logic [IDX_W-1:0] REG_DIV_BOT = 2'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET  = 2'd2;

  localparam logic [RES_W-1:0] DIV_TOP_RST = 20'd100000;
  localparam logic [RES_W-1:0] DIV_BOT_RST = 20'd100000;
  localparam logic [OFF_W-1:0] OFFSET_RST  = 12'd0;

  // Scaling constants
  localparam logic [CODE_W-1:0] FULL_SCALE_MV = 12'd3300;
  localparam logic [CODE_W-1:0] CODE_MAX      = 12'd4095;
  // Divider numerator: scaled mV (12 bits) times top+bottom (21 bits)
  localparam int unsigned SUM_W = RES_W + 1;
  localparam int unsigned NUM_W = CODE_W + SUM_W;
  localparam int unsigned CNT_W = $clog2(NUM_W);
  // Pre-offset clamp and final clamp
  localparam int unsigned PRE_W = 17;
  localparam logic [PRE_W-1:0] PRE_MAX = 17'd69631;
  localparam logic [MV_W-1:0]  OUT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [CODE_W-1:0] sample_code;
  } in_beat_t;

  typedef struct packed {
    logic [MV_W-1:0]   battery_mv;
    logic [CODE_W-1:0] median_code;
  } out_beat_t;

  // Configuration seen by the arithmetic unit
  typedef struct packed {
    logic [RES_W-1:0] div_top;
    logic [RES_W-1:0] div_bot;
    logic [OFF_W-1:0] offset;
  } cfg_t;

  // What one sorter cell hands to its right neighbor
  typedef struct packed {
    logic [CODE_W-1:0] val;
    logic              ins;
  } cell_link_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_SCALE,
    A_PROD,
    A_DIV,
    A_DONE
  } arith_state_e;

endpackage

@@ rtl/core/mbv_in_if.sv @@
// Input stream interface: valid/ready handshake carrying one ADC code beat.
// Depends on mbv_pkg.
interface mbv_in_if;
  import mbv_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/mbv_out_if.sv @@
// Result stream interface: valid/ready handshake carrying one voltage beat.
// Depends on mbv_pkg.
interface mbv_out_if;
  import mbv_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/median_battery_voltage.sv @@
// Median battery voltage: sorter chain of cells, APB register file and
// arithmetic unit. Depends on mbv_pkg, mbv_in_if, mbv_out_if, mbv_cell, mbv_arith.
//
//   channel    dir  handshake       payload
//   sample_i   in   valid/ready     sample_code[11:0]
//   result_o   out  valid/ready     battery_mv[15:0], median_code[11:0]
//   apb        in   psel/penable    paddr[3:0], pwdata[31:0] -> prdata[31:0]
//
// Each code beat is sorted into the cell row as soon as it is taken. After the
// last code of a batch the input pauses while the median is handed to the
// arithmetic unit, whose scale, product, 33-step serial divide and done states
// then yield the result beat. A batch may fill while the previous result is
// worked on or waits; only its last code stalls until that result has been
// taken. Reset clears the fill count and output valid; registers take defaults.
module median_battery_voltage #(
  parameter int unsigned NUM_SAMPLES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mbv_in_if.sink                      sample_i,
  mbv_out_if.source                   result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbv_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import mbv_pkg::*;

  localparam int unsigned CW = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;

  // Configuration registers
  logic [RES_W-1:0] div_top_q, div_bot_q;
  logic [OFF_W-1:0] offset_q;
  logic             wr_en;
  logic [IDX_W-1:0] reg_idx;
  cfg_t             cfg;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_top_q <= DIV_TOP_RST;
      div_bot_q <= DIV_BOT_RST;
      offset_q  <= OFFSET_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DIV_TOP: div_top_q <= pwdata[RES_W-1:0];
        REG_DIV_BOT: div_bot_q <= pwdata[RES_W-1:0];
        REG_OFFSET:  offset_q  <= pwdata[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIV_TOP: prdata = {{(32-RES_W){1'b0}}, div_top_q};
      REG_DIV_BOT: prdata = {{(32-RES_W){1'b0}}, div_bot_q};
      REG_OFFSET:  prdata = {{(32-OFF_W){1'b0}}, offset_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg.div_top = div_top_q;
  assign cfg.div_bot = div_bot_q;
  assign cfg.offset  = offset_q;

  // Batch control
  logic [CW-1:0] count_q;
  logic          full_q;
  logic          last;
  logic          accept;
  logic          arith_busy;

  assign last           = (count_q == CW'(NUM_SAMPLES - 1));
  assign sample_i.ready = !full_q && !(last && arith_busy);
  assign accept         = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      full_q  <= 1'b0;
    end else begin
      full_q <= accept && last;
      if (accept) begin
        count_q <= last ? '0 : count_q + 1'b1;
      end
    end
  end

  // Sorter row
  cell_link_t chain [NUM_SAMPLES];
  cell_link_t head;

  assign head.val = '0;
  assign head.ins = 1'b0;

  for (genvar i = 0; i < NUM_SAMPLES; i++) begin : g_cell
    cell_link_t left;
    if (i == 0) begin : g_head
      assign left = head;
    end else begin : g_link
      assign left = chain[i-1];
    end
    mbv_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .en_i    (accept),
      .code_i  (sample_i.data.sample_code),
      .count_i (count_q),
      .left_i  (left),
      .link_o  (chain[i])
    );
  end

  // Median taps at fixed cells of the full row
  logic [CODE_W-1:0] median;

  if ((NUM_SAMPLES % 2) == 0) begin : g_even
    logic [CODE_W:0] mid_sum;
    assign mid_sum = {1'b0, chain[NUM_SAMPLES/2-1].val} + {1'b0, chain[NUM_SAMPLES/2].val};
    assign median  = mid_sum[CODE_W:1];
  end else begin : g_odd
    assign median = chain[NUM_SAMPLES/2].val;
  end

  // Arithmetic unit with output register
  mbv_arith u_arith (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (full_q),
    .median_i    (median),
    .cfg_i       (cfg),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .out_beat_o  (result_o.data),
    .busy_o      (arith_busy)
  );

endmodule

@@ rtl/core/mbv_cell.sv @@
// One cell of the insertion sorter chain: holds one code, keeps the row
// sorted ascending by taking either the new code or its left neighbor's.
// Depends on mbv_pkg.
module mbv_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 3
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [mbv_pkg::CODE_W-1:0] code_i,
  input  logic [CW-1:0]             count_i,
  input  mbv_pkg::cell_link_t       left_i,
  output mbv_pkg::cell_link_t       link_o
);
  import mbv_pkg::*;

  logic [CODE_W-1:0] val_q, val_d;
  logic              vld;
  logic              ins;

  // Cell holds a batch code when its position is below the fill count
  assign vld = (count_i > CW'(IDX));
  // New code lands at or left of this cell
  assign ins = !vld || (code_i < val_q);

  always_comb begin
    val_d = val_q;
    if (ins) begin
      val_d = left_i.ins ? left_i.val : code_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

  assign link_o.val = val_q;
  assign link_o.ins = ins;

endmodule

@@ rtl/core/mbv_arith.sv @@
// Arithmetic unit: scales the median code to mV, undoes the resistor
// divider with a bit-serial restoring divider, clamps, adds the signed offset, clamps.
// Depends on mbv_pkg.
module mbv_arith (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mbv_pkg::CODE_W-1:0] median_i,
  input  mbv_pkg::cfg_t              cfg_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output mbv_pkg::out_beat_t         out_beat_o,
  output logic                       busy_o
);
  import mbv_pkg::*;

  arith_state_e state_q, state_d;

  logic [CODE_W-1:0] median_q;
  logic [CODE_W-1:0] mv_q;
  logic [NUM_W-1:0]  num_q;
  logic [RES_W-1:0]  rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              out_valid_q;
  out_beat_t         out_q;

  // Scale: floor(m*3300/4095) as p = q0*4096 + lo = q0*4095 + (q0 + lo)
  logic [2*CODE_W-1:0] prod;
  logic [CODE_W-1:0]   q0;
  logic [CODE_W:0]     r0;
  logic [CODE_W-1:0]   mv_d;

  assign prod = median_q * FULL_SCALE_MV;
  assign q0   = prod[2*CODE_W-1:CODE_W];
  assign r0   = {1'b0, prod[CODE_W-1:0]} + {1'b0, q0};
  assign mv_d = (r0 >= {1'b0, CODE_MAX}) ? q0 + 1'b1 : q0;

  // Numerator for the divider step
  logic [SUM_W-1:0] res_sum;
  logic [NUM_W-1:0] num_prod;

  assign res_sum  = {1'b0, cfg_i.div_top} + {1'b0, cfg_i.div_bot};
  assign num_prod = mv_q * res_sum;

  // One restoring step
  logic [RES_W:0] trial;
  logic           ge;
  logic [RES_W:0] trial_sub;

  assign trial     = {rem_q, num_q[NUM_W-1]};
  assign ge        = (trial >= {1'b0, cfg_i.div_bot});
  assign trial_sub = trial - {1'b0, cfg_i.div_bot};

  // Clamp, offset, clamp
  logic [PRE_W-1:0] pre;
  logic [PRE_W+1:0] sum;
  logic [MV_W-1:0]  mv_final;

  always_comb begin
    if ((|num_q[NUM_W-1:PRE_W]) || (num_q[PRE_W-1:0] > PRE_MAX)) begin
      pre = PRE_MAX;
    end else begin
      pre = num_q[PRE_W-1:0];
    end
    sum = {2'b00, pre} + {{(PRE_W+2-OFF_W){cfg_i.offset[OFF_W-1]}}, cfg_i.offset};
    if (cfg_i.div_bot == '0) begin
      mv_final = OUT_MAX;
    end else if (sum[PRE_W+1]) begin
      mv_final = '0;
    end else if (|sum[PRE_W:MV_W]) begin
      mv_final = OUT_MAX;
    end else begin
      mv_final = sum[MV_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      A_IDLE:  if (start_i) state_d = A_SCALE;
      A_SCALE: state_d = A_PROD;
      A_PROD:  state_d = A_DIV;
      A_DIV:   if (cnt_q == CNT_W'(NUM_W - 1)) state_d = A_DONE;
      A_DONE:  state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy_o = out_valid_q;
    case (state_q)
      A_IDLE:  busy_o = out_valid_q;
      default: busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= A_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == A_DONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      A_IDLE: begin
        if (start_i) median_q <= median_i;
      end
      A_SCALE: mv_q <= mv_d;
      A_PROD: begin
        num_q <= num_prod;
        rem_q <= '0;
        cnt_q <= '0;
      end
      A_DIV: begin
        rem_q <= ge ? trial_sub[RES_W-1:0] : trial[RES_W-1:0];
        num_q <= {num_q[NUM_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
      end
      A_DONE: begin
        out_q.battery_mv  <= mv_final;
        out_q.median_code <= median_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule
